// ===== rtl/cptt_pkg.sv =====
// ----------------------------------------------------------------------------
// cptt_pkg
// Shared widths, constants and types of the camera pan target tracker.
// ----------------------------------------------------------------------------
package cptt_pkg;

    localparam int BLOCKS_IN  = 4;
    localparam int SIG_W      = 3;
    localparam int X_W        = 9;
    localparam int CNT_W      = 8;
    localparam int ANGLE_W    = 8;
    localparam int MISS_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    localparam logic [MISS_W-1:0]  MISS_LIMIT    = 4'd8;
    localparam logic [MISS_W-1:0]  MISS_MAX      = 4'd15;
    localparam logic [ANGLE_W-1:0] REQUEST_ANGLE = 8'd90;
    localparam logic [ANGLE_W-1:0] START_ANGLE   = 8'd90;
    localparam logic [X_W-1:0]     WIN_LOW_RST   = 9'd140;
    localparam logic [X_W-1:0]     WIN_HIGH_RST  = 9'd180;
    localparam logic [CNT_W-1:0]   INTERVAL_RST  = 8'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HIGH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACT_INTERVAL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ANGLE  = 3'd3;

    typedef struct packed {
        logic in_win;
        logic dec;
        logic inc;
    } t_lane_res;

    typedef struct packed {
        logic busy;
        logic done;
    } t_rem_stat;

endpackage

// ===== rtl/cptt_frame_if.sv =====
// ----------------------------------------------------------------------------
// cptt_frame_if
// Frame channel: one beat per camera frame.
// ----------------------------------------------------------------------------
interface cptt_frame_if;
    logic                        valid;
    logic                        ready;
    logic                        reset_request;
    logic [cptt_pkg::SIG_W-1:0]  target_signature;
    logic [cptt_pkg::CNT_W-1:0]  block_count;
    logic [cptt_pkg::SIG_W-1:0]  block0_signature;
    logic [cptt_pkg::X_W-1:0]    block0_x;
    logic [cptt_pkg::SIG_W-1:0]  block1_signature;
    logic [cptt_pkg::X_W-1:0]    block1_x;
    logic [cptt_pkg::SIG_W-1:0]  block2_signature;
    logic [cptt_pkg::X_W-1:0]    block2_x;
    logic [cptt_pkg::SIG_W-1:0]  block3_signature;
    logic [cptt_pkg::X_W-1:0]    block3_x;

    modport source (
        output valid, reset_request, target_signature, block_count,
               block0_signature, block0_x, block1_signature, block1_x,
               block2_signature, block2_x, block3_signature, block3_x,
        input  ready
    );
    modport sink (
        input  valid, reset_request, target_signature, block_count,
               block0_signature, block0_x, block1_signature, block1_x,
               block2_signature, block2_x, block3_signature, block3_x,
        output ready
    );
endinterface

// ===== rtl/cptt_result_if.sv =====
// ----------------------------------------------------------------------------
// cptt_result_if
// Result channel: one beat per processed frame.
// ----------------------------------------------------------------------------
interface cptt_result_if;
    logic                         valid;
    logic                         ready;
    logic [cptt_pkg::ANGLE_W-1:0] servo_command;
    logic [cptt_pkg::ANGLE_W-1:0] next_angle;
    logic                         target_detected;

    modport source (
        output valid, servo_command, next_angle, target_detected,
        input  ready
    );
    modport sink (
        input  valid, servo_command, next_angle, target_detected,
        output ready
    );
endinterface

// ===== rtl/cptt_lane.sv =====
// ----------------------------------------------------------------------------
// cptt_lane
// Per-block classifier: window test and nudge direction for one block.
// ----------------------------------------------------------------------------
module cptt_lane (
    input  logic                        i_present,
    input  logic [cptt_pkg::SIG_W-1:0]  i_sig,
    input  logic [cptt_pkg::X_W-1:0]    i_x,
    input  logic [cptt_pkg::SIG_W-1:0]  i_target,
    input  logic                        i_flag,
    input  logic [cptt_pkg::X_W-1:0]    i_win_low,
    input  logic [cptt_pkg::X_W-1:0]    i_win_high,
    output cptt_pkg::t_lane_res         o_res
);
    import cptt_pkg::*;

    logic w_match;
    logic w_above;

    assign w_match = i_present && (i_sig == i_target);
    assign w_above = i_x > i_win_low;

    always_comb begin
        o_res.in_win = w_match && (i_x >= i_win_low) && (i_x <= i_win_high);
        o_res.dec    = w_match && !i_flag && w_above;
        o_res.inc    = w_match && !i_flag && !w_above && (i_x < i_win_high);
    end
endmodule

// ===== rtl/cptt_rem.sv =====
// ----------------------------------------------------------------------------
// cptt_rem
// Restoring remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cptt_rem (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [cptt_pkg::CNT_W-1:0] i_dividend,
    input  logic [cptt_pkg::CNT_W-1:0] i_divisor,
    output cptt_pkg::t_rem_stat        o_stat,
    output logic [cptt_pkg::CNT_W-1:0] o_rem
);
    import cptt_pkg::*;

    localparam int STEP_W = $clog2(CNT_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CNT_W - 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [CNT_W-1:0]  r_dvd;
    logic [CNT_W-1:0]  r_div;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W:0]    w_shift;
    logic [CNT_W:0]    w_sub;
    logic [CNT_W-1:0]  n_rem;

    always_comb begin
        w_shift = {r_rem, r_dvd[CNT_W-1]};
        w_sub   = w_shift - {1'b0, r_div};
        n_rem   = (w_shift >= {1'b0, r_div}) ? w_sub[CNT_W-1:0] : w_shift[CNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[CNT_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_rem       = r_rem;
endmodule

// ===== rtl/camera_pan_target_tracker_top.sv =====
// ----------------------------------------------------------------------------
// camera_pan_target_tracker_top
// Pan servo tracker: steers a pan angle toward a colored block in a window.
// ----------------------------------------------------------------------------
// Frames arrive on i_frame, one beat per frame; each gives one registered beat
// on o_result. One frame per cycle is sustained while the receiver takes
// results and no phase recompute runs; the single output register is freed in
// the cycle its beat leaves, so a stalled receiver holds i_frame.ready low.
// The tracked blocks are classified in parallel lanes and merged by priority
// in the same cycle, so the state is updated as each frame is taken.
// The act phase (frame count modulo act_interval) is kept incrementally;
// a write to act_interval recomputes it with a bit-serial remainder unit,
// which holds i_frame.ready low until the new phase is loaded.
// Synchronous reset clears counters and flags, loads the default registers
// and sets the pan angle to 90. A start_angle write has no effect on the
// angle, which is loaded only at reset.
// Config writes: i_cfg_we, i_cfg_index, i_cfg_wdata, one cycle each.
// ----------------------------------------------------------------------------
module camera_pan_target_tracker_top #(
    parameter int TRACKED_BLOCKS = 4,
    parameter int FRAME_WRAP     = 200,
    parameter int ANGLE_LIMIT    = 179
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [cptt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cptt_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    cptt_frame_if.sink                      i_frame,
    cptt_result_if.source                   o_result
);
    import cptt_pkg::*;

    localparam int NLANE     = (TRACKED_BLOCKS < BLOCKS_IN) ? TRACKED_BLOCKS : BLOCKS_IN;
    localparam int TOP_INT   = (ANGLE_LIMIT + 1 > 255) ? 255 : ANGLE_LIMIT + 1;
    localparam logic [ANGLE_W-1:0] ANGLE_TOP = ANGLE_W'(TOP_INT);
    localparam logic [ANGLE_W-1:0] ANGLE_LIM = ANGLE_W'(ANGLE_LIMIT);
    localparam logic [CNT_W-1:0]   WRAP      = CNT_W'(FRAME_WRAP);

    function automatic logic [ANGLE_W-1:0] f_inc(input logic [ANGLE_W-1:0] a);
        return (a >= ANGLE_TOP) ? ANGLE_TOP : a + 1'b1;
    endfunction

    function automatic logic [ANGLE_W-1:0] f_dec(input logic [ANGLE_W-1:0] a);
        return (a == '0) ? '0 : a - 1'b1;
    endfunction

    function automatic logic [ANGLE_W-1:0] f_sweep(input logic [ANGLE_W-1:0] a);
        return (a > ANGLE_LIM) ? f_inc('0) : f_inc(a);
    endfunction

    logic [X_W-1:0]     r_win_low;
    logic [X_W-1:0]     r_win_high;
    logic [CNT_W-1:0]   r_interval;
    logic [CNT_W-1:0]   r_fc;
    logic [CNT_W-1:0]   r_phase;
    logic [MISS_W-1:0]  r_miss;
    logic [NLANE-1:0]   r_flags;
    logic [ANGLE_W-1:0] r_angle;
    logic               r_out_valid;
    logic [ANGLE_W-1:0] r_out_servo;
    logic [ANGLE_W-1:0] r_out_next;
    logic               r_out_det;

    logic [CNT_W-1:0]   n_fc;
    logic [CNT_W-1:0]   n_phase;
    logic [MISS_W-1:0]  n_miss;
    logic [NLANE-1:0]   n_flags;
    logic [ANGLE_W-1:0] n_angle;

    logic [SIG_W-1:0]   w_sig [BLOCKS_IN];
    logic [X_W-1:0]     w_x   [BLOCKS_IN];
    t_lane_res          w_lane [NLANE];
    logic [NLANE-1:0]   w_inwin;
    logic [ANGLE_W-1:0] w_a0;
    logic [NLANE-1:0]   w_f0;
    logic [MISS_W-1:0]  w_m0;
    logic [MISS_W-1:0]  w_mi;
    logic [ANGLE_W-1:0] w_nudged;
    logic               w_moved;
    logic [CNT_W-1:0]   w_ivl;
    logic [CNT_W:0]     w_phase_inc;
    logic [CNT_W-1:0]   w_fc_inc;
    logic               w_acting;
    logic               w_accept;
    logic               w_in_ready;
    logic               w_rem_start;
    t_rem_stat          w_rem_stat;
    logic [CNT_W-1:0]   w_rem;
    logic [CNT_W-1:0]   w_cfg_ivl;

    assign w_sig[0] = i_frame.block0_signature;
    assign w_sig[1] = i_frame.block1_signature;
    assign w_sig[2] = i_frame.block2_signature;
    assign w_sig[3] = i_frame.block3_signature;
    assign w_x[0]   = i_frame.block0_x;
    assign w_x[1]   = i_frame.block1_x;
    assign w_x[2]   = i_frame.block2_x;
    assign w_x[3]   = i_frame.block3_x;

    assign w_a0 = i_frame.reset_request ? REQUEST_ANGLE : r_angle;
    assign w_f0 = i_frame.reset_request ? '0 : r_flags;
    assign w_m0 = i_frame.reset_request ? '0 : r_miss;

    genvar k;
    generate
        for (k = 0; k < NLANE; k++) begin : g_lane
            cptt_lane u_lane (
                .i_present  (i_frame.block_count > CNT_W'(k)),
                .i_sig      (w_sig[k]),
                .i_x        (w_x[k]),
                .i_target   (i_frame.target_signature),
                .i_flag     (w_f0[k]),
                .i_win_low  (r_win_low),
                .i_win_high (r_win_high),
                .o_res      (w_lane[k])
            );
            assign w_inwin[k] = w_lane[k].in_win;
        end
    endgenerate

    // priority merge: lowest lane with a nudge wins
    always_comb begin
        w_moved  = 1'b0;
        w_nudged = w_a0;
        for (int i = 0; i < NLANE; i++) begin
            if (!w_moved && (w_lane[i].dec || w_lane[i].inc)) begin
                w_moved  = 1'b1;
                w_nudged = w_lane[i].dec ? f_dec(w_a0) : f_inc(w_a0);
            end
        end
    end

    always_comb begin
        w_ivl       = (r_interval == '0) ? CNT_W'(1) : r_interval;
        w_phase_inc = {1'b0, r_phase} + 1'b1;
        w_fc_inc    = r_fc + 1'b1;
        w_acting    = (w_phase_inc == {1'b0, w_ivl});
        if (w_fc_inc == WRAP) begin
            n_fc    = '0;
            n_phase = '0;
        end else begin
            n_fc    = w_fc_inc;
            n_phase = w_acting ? '0 : w_phase_inc[CNT_W-1:0];
        end
    end

    always_comb begin
        w_mi    = (w_m0 < MISS_MAX) ? w_m0 + 1'b1 : w_m0;
        n_angle = w_a0;
        n_flags = w_f0;
        n_miss  = w_m0;
        if (w_acting && (i_frame.block_count != '0)) begin
            n_miss  = '0;
            n_flags = w_inwin;
            if (w_moved) begin
                n_angle = w_nudged;
            end else if (w_inwin == '0) begin
                n_angle = f_sweep(w_a0);
            end
        end else if (w_acting) begin
            n_miss = w_mi;
            if (w_mi > MISS_LIMIT) begin
                n_flags = '0;
                n_angle = f_sweep(w_a0);
            end
        end
    end

    assign w_cfg_ivl   = (i_cfg_wdata[CNT_W-1:0] == '0) ? CNT_W'(1) : i_cfg_wdata[CNT_W-1:0];
    assign w_rem_start = i_cfg_we && (i_cfg_index == CFG_ACT_INTERVAL);

    cptt_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_rem_start),
        .i_dividend (r_fc),
        .i_divisor  (w_cfg_ivl),
        .o_stat     (w_rem_stat),
        .o_rem      (w_rem)
    );

    assign w_in_ready = i_rst_n && !w_rem_stat.busy && !w_rem_stat.done &&
                        (!r_out_valid || o_result.ready);
    assign w_accept   = i_frame.valid && w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_low   <= WIN_LOW_RST;
            r_win_high  <= WIN_HIGH_RST;
            r_interval  <= INTERVAL_RST;
            r_fc        <= '0;
            r_phase     <= '0;
            r_miss      <= '0;
            r_flags     <= '0;
            r_angle     <= START_ANGLE;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_WINDOW_LOW:   r_win_low  <= i_cfg_wdata;
                    CFG_WINDOW_HIGH:  r_win_high <= i_cfg_wdata;
                    CFG_ACT_INTERVAL: r_interval <= i_cfg_wdata[CNT_W-1:0];
                    CFG_START_ANGLE:  ;
                    default:          ;
                endcase
            end
            if (w_rem_stat.done) begin
                r_phase <= w_rem;
            end
            if (w_accept) begin
                r_fc        <= n_fc;
                r_phase     <= n_phase;
                r_miss      <= n_miss;
                r_flags     <= n_flags;
                r_angle     <= n_angle;
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_servo <= w_a0;
            r_out_next  <= n_angle;
            r_out_det   <= |n_flags;
        end
    end

    assign i_frame.ready            = w_in_ready;
    assign o_result.valid           = r_out_valid;
    assign o_result.servo_command   = r_out_servo;
    assign o_result.next_angle      = r_out_next;
    assign o_result.target_detected = r_out_det;

    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_rem_stat.busy || w_rem_stat.done) |-> !i_frame.ready)
        else $error("frame taken during phase recompute");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_rem_stat.busy && !w_rem_stat.done) |-> (r_phase < w_ivl))
        else $error("act phase out of range");

    a_fc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fc < WRAP)
        else $error("frame counter past wrap");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_angle <= ANGLE_TOP)
        else $error("pan angle above top");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_result.valid)
        else $error("no result after accepted frame");
endmodule
